@@ hw/rtl/sound_activated_block_gate_macros.svh @@
// Assertion macros for the sound-activated block gate.
`ifndef SOUND_ACTIVATED_BLOCK_GATE_MACROS_SVH
`define SOUND_ACTIVATED_BLOCK_GATE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SABG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sabg assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SABG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sabg assertion failed");

`endif

@@ hw/rtl/sabg_pkg.sv @@
// Package for the sound-activated block gate: widths, reset values, register codes.
package sabg_pkg;

  localparam int SAMPLE_W        = 16;
  localparam int CFG_W           = 16;
  localparam int CFG_IDX_W       = 1;
  localparam int BLOCK_LEN_DEF   = 128;

  localparam logic [CFG_W-1:0] LEVEL_THRESHOLD_RST = 16'd3277;
  localparam logic [CFG_W-1:0] HOLD_BLOCKS_RST     = 16'd375;
  localparam logic [CFG_W-1:0] SILENCE_MAX         = 16'hFFFF;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [SAMPLE_W:0]          magnitude_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEVEL_THRESHOLD = 1'b0,
    CFG_HOLD_BLOCKS     = 1'b1
  } cfg_reg_t;

endpackage

@@ hw/rtl/sound_activated_block_gate.sv @@
// Sound-activated block gate: block-level noise gate with hold time and one-block delay line.
//
// Takes one sample beat per cycle and returns a registered result beat per accepted sample,
// sustaining one sample per clock unless out_stall holds. Each result carries the sample
// from the same position of the previous block, read from a single-port line store of
// BLOCK_LEN entries (read before write at the same address, read data registered), so
// the store port is what fixes the rate. The loud/quiet decision, start and end pulses
// are produced on the beat of the last sample of each block; sample_kept on every beat
// tells whether the previous block belongs to a recording. in_stall follows out_stall
// while a result is waiting in the output register. The store is not cleared at reset:
// sample_out is undefined for the whole first block after reset.
module sound_activated_block_gate #(
  parameter int BLOCK_LEN = sabg_pkg::BLOCK_LEN_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // sample input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [sabg_pkg::SAMPLE_W-1:0] in_sample_in,
  input  logic                            in_stop_request,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [sabg_pkg::SAMPLE_W-1:0] out_sample_out,
  output logic                            out_sample_kept,
  output logic                            out_recording_started,
  output logic                            out_recording_ended,
  output logic                            out_block_end,
  // configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sabg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sabg_pkg::CFG_W-1:0]      cfg_data
);

  import sabg_pkg::*;

  localparam int POS_W = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(BLOCK_LEN - 1);

  // configuration
  logic [CFG_W-1:0] level_threshold_r;
  logic [CFG_W-1:0] hold_blocks_r;

  // gate state
  logic [POS_W-1:0] pos_r,     pos_nxt;
  logic             loud_r,    loud_nxt;
  logic [CFG_W-1:0] silence_r, silence_nxt;
  logic             rec_r,     rec_nxt;
  logic             kept_r,    kept_nxt;

  // line store
  logic [SAMPLE_W-1:0] line_mem [BLOCK_LEN];
  logic [SAMPLE_W-1:0] rd_data_r;

  // output register
  logic out_valid_r;
  logic out_kept_r;
  logic out_started_r, started_nxt;
  logic out_ended_r,   ended_nxt;
  logic out_block_end_r;

  logic       in_acc;
  logic       last;
  logic       loud;
  magnitude_t s_ext;
  magnitude_t mag;
  logic       rec_after_start;
  logic [CFG_W-1:0] silence_inc;
  logic       end_silence;
  logic       rec_after_silence;
  logic       end_stop;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r & out_stall;
  assign in_acc    = in_valid & ~in_stall;

  assign s_ext = {in_sample_in[SAMPLE_W-1], in_sample_in};
  assign mag   = in_sample_in[SAMPLE_W-1] ? (~s_ext + magnitude_t'(1)) : s_ext;
  assign loud  = loud_r | (mag > {1'b0, level_threshold_r});
  assign last  = (pos_r == POS_LAST);

  always_comb begin
    rec_after_start   = rec_r | loud;
    silence_inc       = (silence_r == SILENCE_MAX) ? silence_r : silence_r + CFG_W'(1);
    end_silence       = ~loud & rec_r & (silence_inc > hold_blocks_r);
    rec_after_silence = rec_after_start & ~end_silence;
    end_stop          = in_stop_request & rec_after_silence;

    pos_nxt     = pos_r;
    loud_nxt    = loud_r;
    silence_nxt = silence_r;
    rec_nxt     = rec_r;
    kept_nxt    = kept_r;
    started_nxt = 1'b0;
    ended_nxt   = 1'b0;

    if (last) begin
      pos_nxt     = '0;
      loud_nxt    = 1'b0;
      silence_nxt = loud ? '0 : silence_inc;
      rec_nxt     = rec_after_silence & ~in_stop_request;
      kept_nxt    = rec_after_start;
      started_nxt = loud & ~rec_r;
      ended_nxt   = end_silence | end_stop;
    end else begin
      pos_nxt  = pos_r + POS_W'(1);
      loud_nxt = loud;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_threshold_r <= LEVEL_THRESHOLD_RST;
      hold_blocks_r     <= HOLD_BLOCKS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_LEVEL_THRESHOLD: level_threshold_r <= cfg_data;
        CFG_HOLD_BLOCKS:     hold_blocks_r     <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      loud_r    <= 1'b0;
      silence_r <= '0;
      rec_r     <= 1'b0;
      kept_r    <= 1'b0;
    end else if (in_acc) begin
      pos_r     <= pos_nxt;
      loud_r    <= loud_nxt;
      silence_r <= silence_nxt;
      rec_r     <= rec_nxt;
      kept_r    <= kept_nxt;
    end
  end

  // read before write at the same address
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_data_r      <= line_mem[pos_r];
      line_mem[pos_r] <= in_sample_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_kept_r      <= kept_r;
      out_started_r   <= started_nxt;
      out_ended_r     <= ended_nxt;
      out_block_end_r <= last;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_sample_out        = sample_t'(rd_data_r);
  assign out_sample_kept       = out_kept_r;
  assign out_recording_started = out_started_r;
  assign out_recording_ended   = out_ended_r;
  assign out_block_end         = out_block_end_r;

`include "sound_activated_block_gate_macros.svh"

  // pulses only on the last position of a block
  `SABG_ASSERT_NOW(a_pulse_on_block_end, clk, rst_n, out_valid_r && (out_started_r || out_ended_r), out_block_end_r)
  // position steps by one inside a block
  `SABG_ASSERT_NEXT(a_pos_step, clk, rst_n, in_acc && !last, pos_r == $past(pos_r) + POS_W'(1))
  // a loud block clears the silence count
  `SABG_ASSERT_NEXT(a_loud_clears_count, clk, rst_n, in_acc && last && loud, silence_r == '0)
  // a start without an end leaves recording running
  `SABG_ASSERT_NEXT(a_start_sets_rec, clk, rst_n, in_acc && started_nxt && !ended_nxt, rec_r)

endmodule

@@ tb/sound_activated_block_gate_tb.sv @@
// Self-checking testbench for the block noise gate: directed block scenarios, then random traffic.
module sound_activated_block_gate_tb;
  import sabg_pkg::*;

  localparam int BLOCK_LEN = BLOCK_LEN_DEF;

  typedef struct {
    sample_t sample;
    logic    sample_known;
    logic    kept;
    logic    started;
    logic    ended;
    logic    block_end;
  } gate_beat_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  sample_t              in_sample_in;
  logic                 in_stop_request;
  logic                 out_valid;
  logic                 out_stall;
  sample_t              out_sample_out;
  logic                 out_sample_kept;
  logic                 out_recording_started;
  logic                 out_recording_ended;
  logic                 out_block_end;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  // gate model state
  sample_t gate_store [BLOCK_LEN];
  bit      gate_written [BLOCK_LEN];
  int      gate_pos = 0;
  logic    gate_loud = 1'b0;
  int      gate_silence = 0;
  logic    gate_recording = 1'b0;
  logic    gate_prev_kept = 1'b0;
  int      thr_level = int'(LEVEL_THRESHOLD_RST);
  int      hold_limit = int'(HOLD_BLOCKS_RST);

  gate_beat_t pending_beats [$];

  int in_gap_max = 19;
  int stall_max = 19;
  int mismatches = 0;
  int beats_checked = 0;
  int samples_sent = 0;
  int blocks_decided = 0;
  int starts_seen = 0;
  int ends_seen = 0;
  int cfg_writes = 0;

  sound_activated_block_gate #(.BLOCK_LEN(BLOCK_LEN)) u_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_sample_in          (in_sample_in),
    .in_stop_request       (in_stop_request),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_sample_out        (out_sample_out),
    .out_sample_kept       (out_sample_kept),
    .out_recording_started (out_recording_started),
    .out_recording_ended   (out_recording_ended),
    .out_block_end         (out_block_end),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic gate_beat_t predict_gate(input sample_t v, input logic stop);
    gate_beat_t r;
    int         mag;
    logic       loud;
    logic       kept;
    mag = (v < 0) ? -int'(v) : int'(v);
    r.sample = gate_store[gate_pos];
    r.sample_known = gate_written[gate_pos];
    r.kept = gate_prev_kept;
    r.started = 1'b0;
    r.ended = 1'b0;
    r.block_end = (gate_pos == BLOCK_LEN - 1);
    gate_store[gate_pos] = v;
    gate_written[gate_pos] = 1'b1;
    loud = gate_loud || (mag > thr_level);
    if (r.block_end) begin
      if (loud) begin
        if (!gate_recording) begin
          gate_recording = 1'b1;
          r.started = 1'b1;
        end
        gate_silence = 0;
      end
      kept = gate_recording;
      if (!loud) begin
        if (gate_silence != 65535) gate_silence++;
        if (gate_recording && gate_silence > hold_limit) begin
          gate_recording = 1'b0;
          r.ended = 1'b1;
        end
      end
      if (stop && gate_recording) begin
        gate_recording = 1'b0;
        r.ended = 1'b1;
      end
      gate_prev_kept = kept;
      gate_loud = 1'b0;
      gate_pos = 0;
      blocks_decided++;
      if (r.started) starts_seen++;
      if (r.ended) ends_seen++;
    end else begin
      gate_loud = loud;
      gate_pos++;
    end
    return r;
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH %s", msg);
  endtask

  // magnitude never above limit
  function automatic sample_t quiet_sample(input int limit);
    int m;
    m = $urandom_range(0, limit);
    if ($urandom_range(0, 1) == 1) m = -m;
    if (m > 32767) m = 32767;
    return sample_t'(m);
  endfunction

  // magnitude strictly above thr, where that is possible
  function automatic sample_t loud_sample(input int thr);
    int m;
    if (thr >= 32768) return quiet_sample(thr);
    m = $urandom_range(thr + 1, 32768);
    if (m == 32768 || $urandom_range(0, 1) == 1) m = -m;
    return sample_t'(m);
  endfunction

  task automatic send_sample(input sample_t v, input logic stop);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_sample_in <= v;
    in_stop_request <= stop;
    do @(posedge clk); while (in_stall);
    pending_beats.push_back(predict_gate(v, stop));
    samples_sent++;
    @(negedge clk);
  endtask

  // one aligned block; stop bits off the last position are random and must be ignored
  task automatic send_block(input int amp, input int mark_pos, input sample_t mark_val,
                            input logic stop_last);
    sample_t v;
    logic    st;
    for (int i = 0; i < BLOCK_LEN; i++) begin
      v = (i == mark_pos) ? mark_val : quiet_sample(amp);
      st = (i == BLOCK_LEN - 1) ? stop_last : logic'($urandom_range(0, 1));
      send_sample(v, st);
    end
  endtask

  task automatic drain_results(input int max_cycles);
    int n;
    n = 0;
    in_valid <= 1'b0;
    while (pending_beats.size() != 0 && n < max_cycles) begin
      @(negedge clk);
      n++;
    end
    repeat (3) @(negedge clk);
  endtask

  task automatic cfg_write(input cfg_reg_t idx, input int val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_W'(val);
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_LEVEL_THRESHOLD) thr_level = val;
    else hold_limit = val;
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // first block reads an unwritten store, so its samples go unchecked
  task automatic test_quiet_first_block();
    send_block(3277, 5, -16'sd3277, 1'b1);
  endtask

  task automatic test_level_extremes();
    drain_results(100000);
    cfg_write(CFG_LEVEL_THRESHOLD, 32768);
    cfg_write(CFG_HOLD_BLOCKS, 0);
    send_block(32768, 3, 16'sh8000, 1'b0);
    drain_results(100000);
    cfg_write(CFG_LEVEL_THRESHOLD, 32767);
    send_block(32767, 0, 16'sh8000, 1'b0);
    drain_results(100000);
    cfg_write(CFG_LEVEL_THRESHOLD, 0);
    send_block(0, -1, 16'sd0, 1'b0);
    send_block(0, BLOCK_LEN - 1, 16'sd1, 1'b0);
  endtask

  // recording still runs from the level test; the second quiet block exceeds the hold
  task automatic test_hold_expiry();
    drain_results(100000);
    cfg_write(CFG_LEVEL_THRESHOLD, 1000);
    cfg_write(CFG_HOLD_BLOCKS, 1);
    repeat (2) send_block(1000, -1, 16'sd0, 1'b0);
  endtask

  task automatic test_stop_request();
    drain_results(100000);
    cfg_write(CFG_HOLD_BLOCKS, 3);
    send_block(1000, 7, 16'sd1001, 1'b1);
    send_block(1000, 100, -16'sd2000, 1'b0);
    send_block(1000, -1, 16'sd0, 1'b1);
  endtask

  task automatic test_long_hold();
    drain_results(100000);
    cfg_write(CFG_LEVEL_THRESHOLD, 3277);
    cfg_write(CFG_HOLD_BLOCKS, 65535);
    send_block(3277, 64, 16'sd3278, 1'b0);
    send_block(3277, -1, 16'sd0, 1'b1);
  endtask

  task automatic test_random_traffic();
    int      sent;
    int      span;
    int      kind;
    sample_t v;
    logic    st;
    sent = 0;
    kind = 0;
    while (sent < 250) begin
      drain_results(100000);
      case ($urandom_range(0, 5))
        0: cfg_write(CFG_LEVEL_THRESHOLD, 0);
        1: cfg_write(CFG_LEVEL_THRESHOLD, 32768);
        2: cfg_write(CFG_LEVEL_THRESHOLD, 32767);
        3: cfg_write(CFG_LEVEL_THRESHOLD, $urandom_range(0, 32768));
        default: cfg_write(CFG_LEVEL_THRESHOLD, $urandom_range(200, 8000));
      endcase
      case ($urandom_range(0, 5))
        4: cfg_write(CFG_HOLD_BLOCKS, 65535);
        5: cfg_write(CFG_HOLD_BLOCKS, $urandom_range(0, 65535));
        default: cfg_write(CFG_HOLD_BLOCKS, $urandom_range(0, 3));
      endcase
      in_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 19;
      stall_max = ($urandom_range(0, 3) == 0) ? 0 : 19;
      span = $urandom_range(50, 120);
      repeat (span) begin
        if (gate_pos == 0) kind = $urandom_range(0, 19);
        if (kind < 8) v = quiet_sample(thr_level);
        else if (kind < 15) v = ($urandom_range(0, 47) == 0) ? loud_sample(thr_level)
                                                             : quiet_sample(thr_level);
        else v = sample_t'($urandom_range(0, 65535));
        if (gate_pos == BLOCK_LEN - 1) st = ($urandom_range(0, 3) == 0);
        else st = logic'($urandom_range(0, 1));
        send_sample(v, st);
        sent++;
      end
    end
    in_gap_max = 19;
    stall_max = 19;
  endtask

  always @(posedge clk) begin : check_beats
    gate_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_beats.size() == 0) begin
        flag_mismatch($sformatf("unexpected beat: sample %0d", out_sample_out));
      end else begin
        want = pending_beats.pop_front();
        if ((want.sample_known && out_sample_out !== want.sample) ||
            out_sample_kept !== want.kept || out_recording_started !== want.started ||
            out_recording_ended !== want.ended || out_block_end !== want.block_end) begin
          flag_mismatch($sformatf(
            "beat %0d: exp sample %0d kept %b start %b end %b last %b, got %0d %b %b %b %b",
            beats_checked, want.sample, want.kept, want.started, want.ended,
            want.block_end, out_sample_out, out_sample_kept, out_recording_started,
            out_recording_ended, out_block_end));
        end
        beats_checked++;
      end
    end
  end

  // result side back-pressure
  initial begin : result_sink
    int n;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      n = $urandom_range(0, stall_max);
      if (n != 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      @(negedge clk);
    end
  end

  initial begin
    #20000000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_sample_in = '0;
    in_stop_request = 1'b0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_LEVEL_THRESHOLD;
    cfg_data = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_quiet_first_block();
    test_level_extremes();
    test_hold_expiry();
    test_stop_request();
    test_long_hold();
    test_random_traffic();

    drain_results(100000);
    if (pending_beats.size() != 0)
      flag_mismatch($sformatf("%0d expected beats never arrived", pending_beats.size()));
    $display("Ran %0d samples through %0d block decisions: %0d recordings started, %0d ended.",
             samples_sent, blocks_decided, starts_seen, ends_seen);
    $display("%0d register writes, %0d beats checked, %0d mismatches.",
             cfg_writes, beats_checked, mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
